// ===== rtl/lse_pkg.sv =====
// lse_pkg: shared types, codes and defaults for the LIFO stack engine.
// No dependencies; used by the interfaces, the cell and the top level.
package lse_pkg;

	localparam int DEPTH_DEF      = 32;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OPCODE_W = 3;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 6;
	localparam int CAP_W    = 6;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	localparam logic [OPCODE_W-1:0] OP_PUSH     = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_POP      = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_TOP      = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_CLEAR    = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_TRAVERSE = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	localparam logic REG_CAPACITY = 1'b0;

	// the operation that every cell of the chain performs
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP,
		CELL_ROT
	} cell_op_t;

endpackage

// ===== rtl/lse_ifs.sv =====
// lse_ifs: valid/ready channel interfaces for the LIFO stack engine.
// Depends on lse_pkg for field widths.
interface lse_in_if;
	import lse_pkg::*;
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [WORD_W-1:0]   data_in;

	modport source (output valid, opcode, data_in, input ready);
	modport sink   (input valid, opcode, data_in, output ready);
endinterface

interface lse_out_if;
	import lse_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   data_out;
	logic                data_valid;
	logic [COUNT_W-1:0]  entry_count;
	logic                last;

	modport source (output valid, status, data_out, data_valid, entry_count, last,
		input ready);
	modport sink   (input valid, status, data_out, data_valid, entry_count, last,
		output ready);
endinterface

// ===== rtl/lse_cell.sv =====
// lse_cell: one stack slot; shifts toward its neighbors on push, pop and rotate.
// Depends on lse_pkg for cell_op_t.
module lse_cell
	import lse_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int DEPTH      = DEPTH_DEF,
	parameter int INDEX      = 0,
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  cell_op_t              op,
	input  logic [CNT_W-1:0]      count,
	input  logic [DATA_WIDTH-1:0] word_above,
	input  logic [DATA_WIDTH-1:0] word_below,
	input  logic [DATA_WIDTH-1:0] word_wrap,
	output logic [DATA_WIDTH-1:0] word
);

	logic [DATA_WIDTH-1:0] word_q;
	logic                  at_bottom;
	logic                  above_bottom;

	// rotation only moves the occupied slots; the bottom one takes the old top
	assign at_bottom    = CNT_W'(INDEX + 1) == count;
	assign above_bottom = CNT_W'(INDEX + 1) < count;

	always_ff @(posedge clk) begin
		case (op)
			CELL_PUSH: word_q <= word_above;
			CELL_POP:  word_q <= word_below;
			CELL_ROT: begin
				if (at_bottom) begin
					word_q <= word_wrap;
				end else if (above_bottom) begin
					word_q <= word_below;
				end
			end
			default: word_q <= word_q;
		endcase
	end

	assign word = word_q;

endmodule

// ===== rtl/lifo_stack_engine_unit.sv =====
// lifo_stack_engine_unit: bounded LIFO stack built as a chain of shifting cells.
// Depends on lse_pkg, lse_ifs (lse_in_if, lse_out_if) and lse_cell.
//
// The top of the stack always sits in the first cell; push shifts the chain down,
// pop shifts it up. Push, pop, top, clear and unused opcodes give one result each
// and sustain one transaction per cycle while no traverse is running and the
// result channel keeps up: a single output register holds the result while the
// next item is taken. Traverse with N stored words gives N results and takes
// no input until the last: the occupied cells rotate one place per result and
// the first cell feeds the output; after the last result the order is restored.
// Traverse on an empty stack, like every other opcode, gives one result.
// capacity (APB byte address 0, reset 32) limits pushes; values above DEPTH act
// as DEPTH and lowering it below the count keeps the stored words.
module lifo_stack_engine_unit
	import lse_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lse_in_if.sink      in_ch,
	lse_out_if.source   res_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = 8;

	logic [CAP_W-1:0]      capacity_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic [CNT_W-1:0]      remain_q;
	logic [CNT_W-1:0]      remain_nxt;
	logic                  busy_q;
	logic                  busy_nxt;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [WORD_W-1:0]     data_q;
	logic                  dvalid_q;
	logic [COUNT_W-1:0]    entry_q;
	logic                  last_q;

	logic                  advance;
	logic                  in_fire;
	logic                  emit;
	logic [STATUS_W-1:0]   status_d;
	logic                  word_sel;
	logic                  last_d;
	logic                  full;
	logic                  empty;
	cell_op_t              cell_op;

	logic [DATA_WIDTH-1:0] cell_word [DEPTH];
	logic [DATA_WIDTH-1:0] push_word;
	logic [63:0]           push_ext;
	logic [63:0]           top_ext;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_q) : 32'd0;

	// ---------------- cell chain ----------------
	assign push_ext  = 64'(in_ch.data_in);
	assign push_word = push_ext[DATA_WIDTH-1:0];
	assign top_ext   = 64'(cell_word[0]);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] above;
		logic [DATA_WIDTH-1:0] below;

		if (i == 0) begin : g_first
			assign above = push_word;
		end else begin : g_mid
			assign above = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign below = cell_word[i];
		end else begin : g_inner
			assign below = cell_word[i+1];
		end

		lse_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.DEPTH      (DEPTH),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.op         (cell_op),
			.count      (count_q),
			.word_above (above),
			.word_below (below),
			.word_wrap  (cell_word[0]),
			.word       (cell_word[i])
		);
	end

	// ---------------- control ----------------
	assign advance      = !out_valid_q || res_ch.ready;
	assign in_ch.ready  = advance && !busy_q;
	assign in_fire      = in_ch.valid && in_ch.ready;

	assign empty = count_q == '0;
	assign full  = CMP_W'(count_q) >= CMP_W'(capacity_q) || CMP_W'(count_q) >= CMP_W'(DEPTH);

	always_comb begin
		cell_op    = CELL_HOLD;
		count_nxt  = count_q;
		remain_nxt = remain_q;
		busy_nxt   = busy_q;
		emit       = 1'b0;
		status_d   = ST_OK;
		word_sel   = 1'b0;
		last_d     = 1'b1;
		if (in_fire) begin
			emit = 1'b1;
			unique case (in_ch.opcode)
				OP_PUSH: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						cell_op   = CELL_PUSH;
						count_nxt = count_q + 1'b1;
					end
				end
				OP_POP: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						cell_op   = CELL_POP;
						count_nxt = count_q - 1'b1;
						word_sel  = 1'b1;
					end
				end
				OP_TOP: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						word_sel = 1'b1;
					end
				end
				OP_CLEAR: count_nxt = '0;
				OP_TRAVERSE: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						cell_op    = CELL_ROT;
						word_sel   = 1'b1;
						last_d     = count_q == CNT_W'(1);
						remain_nxt = count_q - 1'b1;
						busy_nxt   = count_q != CNT_W'(1);
					end
				end
				default: ;
			endcase
		end else if (busy_q && advance) begin
			// later traverse results: emit the new top, rotate again
			emit       = 1'b1;
			cell_op    = CELL_ROT;
			word_sel   = 1'b1;
			last_d     = remain_q == CNT_W'(1);
			remain_nxt = remain_q - 1'b1;
			busy_nxt   = remain_q != CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			remain_q    <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q  <= count_nxt;
			remain_q <= remain_nxt;
			busy_q   <= busy_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= status_d;
			data_q   <= word_sel ? top_ext[WORD_W-1:0] : '0;
			dvalid_q <= word_sel;
			entry_q  <= COUNT_W'(count_nxt);
			last_q   <= last_d;
		end
	end

	assign res_ch.valid       = out_valid_q;
	assign res_ch.status      = status_q;
	assign res_ch.data_out    = data_q;
	assign res_ch.data_valid  = dvalid_q;
	assign res_ch.entry_count = entry_q;
	assign res_ch.last        = last_q;

endmodule
